FILE: sv/spst_pkg.sv
// ----------------------------------------------------------------------------
// spst_pkg
// shared types and constants for the staircase pacing stimulus timer
// ----------------------------------------------------------------------------
package spst_pkg;

  // phase counter width
  localparam int TICK_BITS = 16;
  // width of configuration values, period and beat counter
  localparam int VAL_W     = 16;
  // compare width wide enough for phase + 1 and offset + length
  localparam int CMP_W     = (TICK_BITS + 1 > VAL_W + 1) ? TICK_BITS + 1 : VAL_W + 1;
  localparam int IDX_W     = 3;

  // register indexes on the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_PULSE_OFFSET     = 3'd0,
    REG_PULSE_LENGTH     = 3'd1,
    REG_FIRST_PERIOD     = 3'd2,
    REG_LAST_PERIOD      = 3'd3,
    REG_PERIOD_DECREMENT = 3'd4,
    REG_CYCLES_PER_STAGE = 3'd5
  } reg_idx_t;

  // reset values
  localparam logic [VAL_W-1:0] PULSE_OFFSET_RST     = 16'd0;
  localparam logic [VAL_W-1:0] PULSE_LENGTH_RST     = 16'd4;
  localparam logic [VAL_W-1:0] FIRST_PERIOD_RST     = 16'd1000;
  localparam logic [VAL_W-1:0] LAST_PERIOD_RST      = 16'd300;
  localparam logic [VAL_W-1:0] PERIOD_DECREMENT_RST = 16'd50;
  localparam logic [VAL_W-1:0] CYCLES_PER_STAGE_RST = 16'd10;

  typedef struct packed {
    logic [VAL_W-1:0] pulse_offset;
    logic [VAL_W-1:0] pulse_length;
    logic [VAL_W-1:0] first_period;
    logic [VAL_W-1:0] last_period;
    logic [VAL_W-1:0] period_decrement;
    logic [VAL_W-1:0] cycles_per_stage;
  } cfg_t;

  typedef struct packed {
    logic             final_stage;
    logic [VAL_W-1:0] period_now;
    logic             stim_active;
  } result_t;

  // zero reads as one
  function automatic logic [VAL_W-1:0] nonzero(input logic [VAL_W-1:0] v);
    return (v == '0) ? VAL_W'(1) : v;
  endfunction

endpackage

FILE: sv/spst_cfg.sv
// ----------------------------------------------------------------------------
// spst_cfg
// configuration register file, written one register per word
// ----------------------------------------------------------------------------
module spst_cfg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [spst_pkg::IDX_W-1:0] wr_index,
  input  logic [spst_pkg::VAL_W-1:0] wr_data,
  output spst_pkg::cfg_t          cfg
);
  import spst_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_offset     <= PULSE_OFFSET_RST;
      cfg.pulse_length     <= PULSE_LENGTH_RST;
      cfg.first_period     <= FIRST_PERIOD_RST;
      cfg.last_period      <= LAST_PERIOD_RST;
      cfg.period_decrement <= PERIOD_DECREMENT_RST;
      cfg.cycles_per_stage <= CYCLES_PER_STAGE_RST;
    end else if (wr_en) begin
      // indexes past the list are dropped
      unique case (wr_index)
        REG_PULSE_OFFSET:     cfg.pulse_offset     <= wr_data;
        REG_PULSE_LENGTH:     cfg.pulse_length     <= wr_data;
        REG_FIRST_PERIOD:     cfg.first_period     <= wr_data;
        REG_LAST_PERIOD:      cfg.last_period      <= wr_data;
        REG_PERIOD_DECREMENT: cfg.period_decrement <= wr_data;
        REG_CYCLES_PER_STAGE: cfg.cycles_per_stage <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/spst_core.sv
// ----------------------------------------------------------------------------
// spst_core
// protocol state and single-pass tick update, result formed combinationally
// ----------------------------------------------------------------------------
module spst_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              restart,
  input  spst_pkg::cfg_t    cfg,
  output spst_pkg::result_t res
);
  import spst_pkg::*;

  logic [TICK_BITS-1:0] phase_count, phase_count_next;
  logic [VAL_W-1:0]     beat_count, beat_count_next;
  logic [VAL_W-1:0]     period_reg, period_reg_next;
  logic                 at_last_stage, at_last_stage_next;

  logic [TICK_BITS-1:0] phase_eff;
  logic [VAL_W-1:0]     beat_eff;
  logic [VAL_W-1:0]     period_eff;
  logic                 last_eff;
  logic [VAL_W-1:0]     floor_p;
  logic [VAL_W-1:0]     stepped;
  logic                 cannot_step;
  logic [CMP_W-1:0]     phase_x, win_hi, next_x, period_x;
  logic                 beat_end;
  logic [VAL_W-1:0]     beat_inc;

  always_comb begin
    // restart clears the protocol before this tick
    phase_eff  = restart ? '0 : phase_count;
    beat_eff   = restart ? '0 : beat_count;
    period_eff = restart ? nonzero(cfg.first_period) : period_reg;

    floor_p     = nonzero(cfg.last_period);
    stepped     = period_eff - cfg.period_decrement;
    cannot_step = (period_eff <= floor_p) || (cfg.period_decrement == '0) ||
                  (cfg.period_decrement >= period_eff) || (stepped < floor_p);
    last_eff    = (!restart && at_last_stage) || cannot_step;

    // stimulus window, inclusive on both ends
    phase_x = CMP_W'(phase_eff);
    win_hi  = CMP_W'(cfg.pulse_offset) + CMP_W'(cfg.pulse_length);
    res.stim_active = (phase_x >= CMP_W'(cfg.pulse_offset)) && (phase_x <= win_hi);
    res.period_now  = period_eff;
    res.final_stage = last_eff;

    // beat ends at the period or at phase counter overflow
    next_x   = CMP_W'(phase_eff) + CMP_W'(1);
    period_x = CMP_W'(period_eff);
    beat_end = (next_x >= period_x) || next_x[TICK_BITS];
    beat_inc = beat_eff + VAL_W'(1);

    phase_count_next   = beat_end ? '0 : next_x[TICK_BITS-1:0];
    beat_count_next    = beat_eff;
    period_reg_next    = period_eff;
    at_last_stage_next = last_eff;
    if (beat_end) begin
      if (last_eff) begin
        beat_count_next = '0;
      end else if (beat_inc >= nonzero(cfg.cycles_per_stage)) begin
        beat_count_next = '0;
        period_reg_next = stepped;
      end else begin
        beat_count_next = beat_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count   <= '0;
      beat_count    <= '0;
      period_reg    <= nonzero(FIRST_PERIOD_RST);
      at_last_stage <= 1'b0;
    end else if (step) begin
      phase_count   <= phase_count_next;
      beat_count    <= beat_count_next;
      period_reg    <= period_reg_next;
      at_last_stage <= at_last_stage_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    period_reg != '0)
    else $error("pacing period reached zero");

  // a frozen period only thaws on a restart tick
  a_frozen_holds: assert property (@(posedge clk) disable iff (rst)
    (at_last_stage && !(step && restart)) |=> at_last_stage)
    else $error("frozen period released without restart");

  a_phase_in_period: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(phase_count) < CMP_W'(period_reg))
    else $error("phase ran past the period");
`endif

endmodule

FILE: sv/staircase_pacing_stimulus_timer_top.sv
// ----------------------------------------------------------------------------
// staircase_pacing_stimulus_timer_top
// staircase pacing stimulator: one tick word in, one result word out
// ----------------------------------------------------------------------------
// a result word is valid in the cycle after its tick word is accepted
// throughput: one tick word per cycle while the result stream is not stalled, set by the single output register
// the input side stays ready while the output register is empty or drained
// reset (rst, synchronous): registers take their reset values, protocol
// restarts at phase zero with the first period, output register empties
// ----------------------------------------------------------------------------
module staircase_pacing_stimulus_timer_top (
  input  logic        clk,
  input  logic        rst,
  // tick stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] stim_active, [16:1] period_now,
                                      // [17] final_stage, [23:18] zero
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [spst_pkg::IDX_W-1:0] cfg_index,
  input  logic [spst_pkg::VAL_W-1:0] cfg_data
);
  import spst_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_word;
  logic    step;

  // register writes are taken every cycle
  assign cfg_ready = 1'b1;

  spst_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // a tick advances the state in the same cycle its result is captured
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  spst_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .restart (s_axis_tdata[0]),
    .cfg     (cfg),
    .res     (res)
  );

  // output register, valid flag is control and gets reset
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = {6'd0, out_word};

endmodule
